// ===== hw/rtl/ppu_pkg.sv =====
// Package for the particle pool update block: payload structs, slot word,
// controller states, datapath commands and a saturating arithmetic helper.
// No dependencies.
`timescale 1ns / 1ps

package ppu_pkg;

    localparam int POOL_SIZE_DEF = 64;
    localparam int CNT_W         = 7;
    localparam logic [15:0] DRAG_RESET = 16'd512;

    typedef enum logic [1:0] {
        M_EMIT = 2'd0,
        M_TICK = 2'd1,
        M_DRAW = 2'd2,
        M_NONE = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [31:0]        time_value;
        logic [31:0]        color_start;
        logic [31:0]        color_finish;
        logic signed [31:0] size_start;
        logic signed [31:0] size_finish;
    } t_in;

    typedef struct packed {
        logic signed [31:0] left_x;
        logic signed [31:0] top_y;
        logic signed [31:0] sprite_size;
        logic [31:0]        sprite_color;
        logic               sprite_valid;
        logic               last;
        logic [CNT_W-1:0]   active_count;
    } t_out;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [31:0]        life_total;
        logic [31:0]        life_left;
        logic [31:0]        color_start;
        logic [31:0]        color_finish;
        logic signed [31:0] size_start;
        logic signed [31:0] size_finish;
    } t_slot;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_READ,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_WB,
        S_DIV,
        S_SMUL,
        S_SIZE,
        S_OUT,
        S_STAT
    } t_state;

    typedef enum logic [3:0] {
        C_NONE,
        C_LATCH,
        C_EMIT,
        C_TICK_START,
        C_DRAW_START,
        C_SLOT_NEXT,
        C_EXPIRE,
        C_MUL_VXDT,
        C_MUL_VYDT,
        C_MUL_VXF,
        C_MUL_VYF,
        C_TICK_WB,
        C_DIV_START,
        C_DIV_STEP,
        C_SIZE_MUL,
        C_SIZE_CAP
    } t_op;

    typedef struct packed {
        t_op  op;
        logic draw_out;
        logic stat_out;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       scan_done;
        logic       slot_active;
        logic       expire;
        logic       div_done;
        logic       out_free;
        logic       any_drawn;
    } t_status;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > 68'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -68'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

// ===== hw/rtl/ppu_ctrl.sv =====
// Controller of the particle pool update block: sequences emit, tick and draw.
// Depends on ppu_pkg.
`timescale 1ns / 1ps

module ppu_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ppu_pkg::t_status  i_status,
    output ppu_pkg::t_cmd     o_cmd
);

    ppu_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppu_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '{op: ppu_pkg::C_NONE, draw_out: 1'b0, stat_out: 1'b0};
        unique case (r_state)
            ppu_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = ppu_pkg::C_LATCH;
                    n_state  = ppu_pkg::S_DECODE;
                end
            end
            ppu_pkg::S_DECODE: begin
                unique case (ppu_pkg::t_mode'(i_status.mode))
                    ppu_pkg::M_EMIT: begin
                        o_cmd.op = ppu_pkg::C_EMIT;
                        n_state  = ppu_pkg::S_STAT;
                    end
                    ppu_pkg::M_TICK: begin
                        o_cmd.op = ppu_pkg::C_TICK_START;
                        n_state  = ppu_pkg::S_SCAN;
                    end
                    ppu_pkg::M_DRAW: begin
                        o_cmd.op = ppu_pkg::C_DRAW_START;
                        n_state  = ppu_pkg::S_SCAN;
                    end
                    default: begin
                        n_state = ppu_pkg::S_STAT;
                    end
                endcase
            end
            ppu_pkg::S_SCAN: begin
                if (i_status.scan_done) begin
                    if (i_status.mode == ppu_pkg::M_DRAW && i_status.any_drawn) begin
                        n_state = ppu_pkg::S_IDLE;
                    end else begin
                        n_state = ppu_pkg::S_STAT;
                    end
                end else if (i_status.slot_active) begin
                    n_state = ppu_pkg::S_READ;
                end else begin
                    o_cmd.op = ppu_pkg::C_SLOT_NEXT;
                end
            end
            ppu_pkg::S_READ: begin
                if (i_status.mode == ppu_pkg::M_DRAW) begin
                    o_cmd.op = ppu_pkg::C_DIV_START;
                    n_state  = ppu_pkg::S_DIV;
                end else if (i_status.expire) begin
                    o_cmd.op = ppu_pkg::C_EXPIRE;
                    n_state  = ppu_pkg::S_SCAN;
                end else begin
                    o_cmd.op = ppu_pkg::C_MUL_VXDT;
                    n_state  = ppu_pkg::S_MUL1;
                end
            end
            ppu_pkg::S_MUL1: begin
                o_cmd.op = ppu_pkg::C_MUL_VYDT;
                n_state  = ppu_pkg::S_MUL2;
            end
            ppu_pkg::S_MUL2: begin
                o_cmd.op = ppu_pkg::C_MUL_VXF;
                n_state  = ppu_pkg::S_MUL3;
            end
            ppu_pkg::S_MUL3: begin
                o_cmd.op = ppu_pkg::C_MUL_VYF;
                n_state  = ppu_pkg::S_WB;
            end
            ppu_pkg::S_WB: begin
                o_cmd.op = ppu_pkg::C_TICK_WB;
                n_state  = ppu_pkg::S_SCAN;
            end
            ppu_pkg::S_DIV: begin
                if (i_status.div_done) begin
                    n_state = ppu_pkg::S_SMUL;
                end else begin
                    o_cmd.op = ppu_pkg::C_DIV_STEP;
                end
            end
            ppu_pkg::S_SMUL: begin
                o_cmd.op = ppu_pkg::C_SIZE_MUL;
                n_state  = ppu_pkg::S_SIZE;
            end
            ppu_pkg::S_SIZE: begin
                o_cmd.op = ppu_pkg::C_SIZE_CAP;
                n_state  = ppu_pkg::S_OUT;
            end
            ppu_pkg::S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.draw_out = 1'b1;
                    n_state        = ppu_pkg::S_SCAN;
                end
            end
            ppu_pkg::S_STAT: begin
                if (i_status.out_free) begin
                    o_cmd.stat_out = 1'b1;
                    n_state        = ppu_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ppu_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/ppu_dp.sv =====
// Datapath of the particle pool update block: slot memory, active bits,
// shared multiplier, age divider and output register. Depends on ppu_pkg.
`timescale 1ns / 1ps

module ppu_dp #(
    parameter int POOL_SIZE = ppu_pkg::POOL_SIZE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    input  ppu_pkg::t_in      i_in,
    input  ppu_pkg::t_cmd     i_cmd,
    output ppu_pkg::t_status  o_status,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ppu_pkg::t_out     o_out
);

    localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CW = ppu_pkg::CNT_W;

    logic [$bits(ppu_pkg::t_slot)-1:0] mem [POOL_SIZE];

    ppu_pkg::t_in             r_in;
    ppu_pkg::t_slot           r_rd;
    ppu_pkg::t_out            r_out;
    logic                     r_ovalid;
    logic [15:0]              r_drag;
    logic [POOL_SIZE-1:0]     r_active;
    logic [IW-1:0]            r_head;
    logic [IW:0]              r_idx;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_drawn;
    logic signed [31:0]       r_factor;
    logic signed [65:0]       r_prod;
    logic signed [31:0]       r_px, r_py, r_vx;
    logic [31:0]              r_rem;
    logic [15:0]              r_q;
    logic [4:0]               r_dcnt;
    logic                     r_tzero;
    logic signed [33:0]       r_sz;
    logic [31:0]              r_col;

    logic [IW-1:0]            idx;
    logic signed [32:0]       mul_a, mul_b;
    logic signed [65:0]       prod_sh;
    logic [16:0]              t_val;
    logic [47:0]              rd_full;
    logic signed [40:0]       fac_full;
    logic [32:0]              div_sh;
    logic signed [33:0]       half;
    logic signed [31:0]       vy_new;
    ppu_pkg::t_slot           wb_word, emit_word;
    logic [31:0]              col_n;
    logic [25:0]              ch_sum [4];

    assign idx     = r_idx[IW-1:0];
    assign prod_sh = r_prod >>> 16;
    assign t_val   = r_tzero ? 17'd0 : {1'b0, r_q};
    assign rd_full = 48'(r_drag) * 48'(r_in.time_value);
    assign fac_full = 41'sd65536 - $signed({1'b0, rd_full[47:8]});
    assign div_sh  = {r_rem, 1'b0};
    assign half    = r_sz >>> 1;
    assign vy_new  = ppu_pkg::sat32(68'(prod_sh));

    always_comb begin
        mul_a = 33'(r_rd.vel_x);
        mul_b = $signed({1'b0, r_in.time_value});
        unique case (i_cmd.op)
            ppu_pkg::C_MUL_VYDT: begin
                mul_a = 33'(r_rd.vel_y);
            end
            ppu_pkg::C_MUL_VXF: begin
                mul_b = 33'(r_factor);
            end
            ppu_pkg::C_MUL_VYF: begin
                mul_a = 33'(r_rd.vel_y);
                mul_b = 33'(r_factor);
            end
            ppu_pkg::C_SIZE_MUL: begin
                mul_a = 33'(r_rd.size_finish) - 33'(r_rd.size_start);
                mul_b = $signed({16'd0, t_val});
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            ch_sum[k] = 26'(r_rd.color_start[8*k +: 8]) * 26'(17'd65536 - t_val)
                      + 26'(r_rd.color_finish[8*k +: 8]) * 26'(t_val) + 26'd32768;
            col_n[8*k +: 8] = ch_sum[k][23:16];
        end
    end

    always_comb begin
        wb_word           = r_rd;
        wb_word.pos_x     = r_px;
        wb_word.pos_y     = r_py;
        wb_word.vel_x     = r_vx;
        wb_word.vel_y     = vy_new;
        wb_word.life_left = r_rd.life_left - r_in.time_value;
        emit_word = '{pos_x: r_in.pos_x, pos_y: r_in.pos_y, vel_x: r_in.vel_x,
                      vel_y: r_in.vel_y, life_total: r_in.time_value,
                      life_left: r_in.time_value, color_start: r_in.color_start,
                      color_finish: r_in.color_finish, size_start: r_in.size_start,
                      size_finish: r_in.size_finish};
    end

    // Slot memory: one write and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == ppu_pkg::C_EMIT) begin
            mem[r_head] <= emit_word;
        end else if (i_cmd.op == ppu_pkg::C_TICK_WB) begin
            mem[idx] <= wb_word;
        end
        r_rd <= mem[idx];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (i_cmd.op == ppu_pkg::C_LATCH) begin
            r_in <= i_in;
        end
        if (i_cmd.op == ppu_pkg::C_TICK_START) begin
            r_factor <= (fac_full < -41'sd2147483648) ? 32'sh80000000 : fac_full[31:0];
        end
        if (i_cmd.op == ppu_pkg::C_MUL_VYDT) begin
            r_px <= ppu_pkg::sat32(68'(r_rd.pos_x) + 68'(prod_sh));
        end
        if (i_cmd.op == ppu_pkg::C_MUL_VXF) begin
            r_py <= ppu_pkg::sat32(68'(r_rd.pos_y) + 68'(prod_sh));
        end
        if (i_cmd.op == ppu_pkg::C_MUL_VYF) begin
            r_vx <= ppu_pkg::sat32(68'(prod_sh));
        end
        if (i_cmd.op == ppu_pkg::C_DIV_START) begin
            r_tzero <= r_rd.life_left > r_rd.life_total;
            r_rem   <= r_rd.life_total - r_rd.life_left;
            r_q     <= '0;
            r_dcnt  <= '0;
        end else if (i_cmd.op == ppu_pkg::C_DIV_STEP) begin
            if (div_sh >= {1'b0, r_rd.life_total}) begin
                r_rem <= 32'(div_sh - {1'b0, r_rd.life_total});
                r_q   <= {r_q[14:0], 1'b1};
            end else begin
                r_rem <= div_sh[31:0];
                r_q   <= {r_q[14:0], 1'b0};
            end
            r_dcnt <= r_dcnt + 5'd1;
        end
        if (i_cmd.op == ppu_pkg::C_SIZE_CAP) begin
            r_sz  <= 34'(r_rd.size_start) + 34'(prod_sh);
            r_col <= col_n;
        end
        if (i_cmd.draw_out) begin
            r_out.left_x       <= ppu_pkg::sat32(68'(r_rd.pos_x) - 68'(half));
            r_out.top_y        <= ppu_pkg::sat32(68'(r_rd.pos_y) - 68'(half));
            r_out.sprite_size  <= ppu_pkg::sat32(68'(r_sz));
            r_out.sprite_color <= r_col;
            r_out.sprite_valid <= 1'b1;
            r_out.last         <= (r_drawn + CW'(1)) == r_count;
            r_out.active_count <= r_count;
        end else if (i_cmd.stat_out) begin
            r_out <= '{left_x: '0, top_y: '0, sprite_size: '0, sprite_color: '0,
                       sprite_valid: 1'b0, last: 1'b1, active_count: r_count};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_drag   <= ppu_pkg::DRAG_RESET;
            r_active <= '0;
            r_head   <= '0;
            r_idx    <= '0;
            r_count  <= '0;
            r_drawn  <= '0;
        end else begin
            if (i_cmd.draw_out || i_cmd.stat_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_drag <= i_cfg_data;
            end
            unique case (i_cmd.op)
                ppu_pkg::C_EMIT: begin
                    r_active[r_head] <= r_in.time_value != '0;
                    r_count <= r_count - CW'(r_active[r_head])
                             + CW'(r_in.time_value != '0);
                    r_head  <= (r_head == IW'(POOL_SIZE - 1)) ? '0 : r_head + IW'(1);
                end
                ppu_pkg::C_TICK_START, ppu_pkg::C_DRAW_START: begin
                    r_idx   <= '0;
                    r_drawn <= '0;
                end
                ppu_pkg::C_SLOT_NEXT, ppu_pkg::C_TICK_WB: begin
                    r_idx <= r_idx + (IW+1)'(1);
                end
                ppu_pkg::C_EXPIRE: begin
                    r_active[idx] <= 1'b0;
                    r_count <= r_count - CW'(1);
                    r_idx   <= r_idx + (IW+1)'(1);
                end
                default: begin
                end
            endcase
            if (i_cmd.draw_out) begin
                r_drawn <= r_drawn + CW'(1);
                r_idx   <= r_idx + (IW+1)'(1);
            end
        end
    end

    assign o_status = '{mode: r_in.mode,
                        scan_done: r_idx == (IW+1)'(POOL_SIZE),
                        slot_active: r_active[idx],
                        expire: r_in.time_value >= r_rd.life_left,
                        div_done: r_dcnt == 5'd16,
                        out_free: !r_ovalid || i_out_ready,
                        any_drawn: r_drawn != '0};
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

endmodule

// ===== hw/rtl/particle_pool_update_top.sv =====
// Particle pool update: a ring pool of particles with emit, tick and draw.
// One item is in work at a time: a new item is accepted only in the idle state,
// once the last one has handed its final beat to the output register; the slot
// scan and the 16-step age divider set how long a tick or a draw keeps it busy.
// Reset (synchronous, active low) clears all slots to inactive, the head and
// count to zero and the drag rate to 2.0; slot contents are left as they were.
`timescale 1ns / 1ps

module particle_pool_update_top #(
    parameter int POOL_SIZE = ppu_pkg::POOL_SIZE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ppu_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ppu_pkg::t_out o_out
);

    // The controller walks the states; the datapath holds all storage and
    // arithmetic and reports back through one status struct.
    ppu_pkg::t_cmd    cmd;
    ppu_pkg::t_status status;

    ppu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The output register lets a finished beat wait while the scan goes on
    // to the next slot.
    ppu_dp #(
        .POOL_SIZE (POOL_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ===== tb/ppu_checker.sv =====
// Checker for the particle pool update block: watches both channels, keeps its
// own copy of the pool and compares every output beat with the predicted one.
// Depends on ppu_pkg for the payload structs and the mode codes.
`timescale 1ns / 1ps

module ppu_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_data,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  ppu_pkg::t_in  i_in,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  ppu_pkg::t_out i_out,
    output int            o_errors,
    output int            o_pending
);

    localparam int NSLOT = 64;

    // Shadow copy of the pool.
    logic           live [NSLOT];
    ppu_pkg::t_slot pool [NSLOT];
    logic [5:0]     head;
    logic [15:0]    drag;
    ppu_pkg::t_out  sprite_q[$];

    assign o_pending = sprite_q.size();

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Floor division by 2^s; the arithmetic shift of a signed value floors.
    function automatic longint floor_sh(input longint p, input int s);
        return p >>> s;
    endfunction

    function automatic logic [6:0] live_count();
        logic [6:0] n;
        n = 0;
        for (int i = 0; i < NSLOT; i++) n += live[i];
        return n;
    endfunction

    function automatic logic [31:0] mix_colour(input logic [31:0] b, input logic [31:0] e,
                                               input longint t);
        logic [31:0] r;
        longint      c;
        r = 0;
        for (int k = 0; k < 32; k += 8) begin
            c = (longint'(b[k+:8]) * (65536 - t) + longint'(e[k+:8]) * t + 32768) >>> 16;
            r[k+:8] = c[7:0];
        end
        return r;
    endfunction

    task automatic push_status();
        ppu_pkg::t_out o;
        o = '0;
        o.last = 1'b1;
        o.active_count = live_count();
        sprite_q.push_back(o);
    endtask

    task automatic predict(input ppu_pkg::t_in x);
        longint rd, factor, t, sz, half;
        int     drawn;
        logic [6:0] cnt;
        ppu_pkg::t_out o;
        case (ppu_pkg::t_mode'(x.mode))
            ppu_pkg::M_EMIT: begin
                live[head] = x.time_value != 0;
                pool[head] = '{x.pos_x, x.pos_y, x.vel_x, x.vel_y, x.time_value,
                               x.time_value, x.color_start, x.color_finish,
                               x.size_start, x.size_finish};
                head = head + 1;
                push_status();
            end
            ppu_pkg::M_TICK: begin
                rd = (longint'(drag) * longint'(x.time_value)) >>> 8;
                factor = 65536 - rd;
                if (factor < -64'sd2147483648) factor = -64'sd2147483648;
                for (int i = 0; i < NSLOT; i++) begin
                    if (!live[i]) continue;
                    if (x.time_value >= pool[i].life_left) begin
                        live[i] = 1'b0;
                        continue;
                    end
                    pool[i].life_left -= x.time_value;
                    pool[i].pos_x = clamp32(longint'(pool[i].pos_x) +
                        floor_sh(longint'(pool[i].vel_x) * longint'(x.time_value), 16));
                    pool[i].pos_y = clamp32(longint'(pool[i].pos_y) +
                        floor_sh(longint'(pool[i].vel_y) * longint'(x.time_value), 16));
                    pool[i].vel_x = clamp32(floor_sh(longint'(pool[i].vel_x) * factor, 16));
                    pool[i].vel_y = clamp32(floor_sh(longint'(pool[i].vel_y) * factor, 16));
                end
                push_status();
            end
            ppu_pkg::M_DRAW: begin
                cnt = live_count();
                drawn = 0;
                for (int i = 0; i < NSLOT; i++) begin
                    if (!live[i]) continue;
                    t = 0;
                    if (pool[i].life_total != 0 && pool[i].life_left <= pool[i].life_total)
                        t = (longint'(pool[i].life_total - pool[i].life_left) << 16) /
                            longint'(pool[i].life_total);
                    if (t > 65535) t = 65535;
                    sz = longint'(pool[i].size_start) + floor_sh((longint'(pool[i].size_finish)
                         - longint'(pool[i].size_start)) * t, 16);
                    half = floor_sh(sz, 1);
                    drawn++;
                    o.left_x       = clamp32(longint'(pool[i].pos_x) - half);
                    o.top_y        = clamp32(longint'(pool[i].pos_y) - half);
                    o.sprite_size  = clamp32(sz);
                    o.sprite_color = mix_colour(pool[i].color_start, pool[i].color_finish, t);
                    o.sprite_valid = 1'b1;
                    o.last         = (drawn == cnt);
                    o.active_count = cnt;
                    sprite_q.push_back(o);
                end
                if (drawn == 0) push_status();
            end
            default: push_status();
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        ppu_pkg::t_out w;
        if (!i_rst_n) begin
            for (int i = 0; i < NSLOT; i++) live[i] = 1'b0;
            head = 0;
            drag = ppu_pkg::DRAG_RESET;
            sprite_q.delete();
        end else begin
            if (i_cfg_we) drag = i_cfg_data;
            if (i_in_valid && i_in_ready) predict(i_in);
            if (i_out_valid && i_out_ready) begin
                if (sprite_q.size() == 0) begin
                    report_mismatch("unexpected beat", 0, 0);
                end else begin
                    w = sprite_q.pop_front();
                    if (i_out.left_x !== w.left_x)
                        report_mismatch("left_x", i_out.left_x, w.left_x);
                    if (i_out.top_y !== w.top_y)
                        report_mismatch("top_y", i_out.top_y, w.top_y);
                    if (i_out.sprite_size !== w.sprite_size)
                        report_mismatch("sprite_size", i_out.sprite_size, w.sprite_size);
                    if (i_out.sprite_color !== w.sprite_color)
                        report_mismatch("sprite_color", i_out.sprite_color, w.sprite_color);
                    if (i_out.sprite_valid !== w.sprite_valid)
                        report_mismatch("sprite_valid", i_out.sprite_valid, w.sprite_valid);
                    if (i_out.last !== w.last)
                        report_mismatch("last", i_out.last, w.last);
                    if (i_out.active_count !== w.active_count)
                        report_mismatch("active_count", i_out.active_count, w.active_count);
                end
            end
        end
    end

endmodule

// ===== tb/tb.sv =====
// Top of the particle pool testbench: clock, reset, stimulus, drag settings and
// the verdict. Depends on ppu_pkg, particle_pool_update_top and ppu_checker.
`timescale 1ns / 1ps

module tb;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          cfg_we = 1'b0;
    logic [15:0]   cfg_data = '0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    ppu_pkg::t_in  in_beat = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    ppu_pkg::t_out out_beat;
    int            errors;
    int            pending;

    // Percentages of idle cycles on each side; changed between phases.
    int          send_idle = 0;
    int          recv_stall = 0;
    // While set, the receiver is held off.
    bit          hold_off = 1'b0;
    bit          done = 1'b0;

    always #5 i_clk = ~i_clk;

    particle_pool_update_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_beat),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_beat)
    );

    ppu_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .i_in_ready (in_ready),
        .i_in       (in_beat),
        .i_out_valid(out_valid),
        .i_out_ready(out_ready),
        .i_out      (out_beat),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // The receiver decides afresh on each edge whether to take a beat.
    always @(posedge i_clk) begin
        out_ready <= !hold_off && ($urandom_range(99) >= recv_stall);
    end

    // Offers one beat, with a random gap first, and returns once it is taken.
    // Valid stays high between beats unless a random gap is drawn.
    task automatic send_beat(input ppu_pkg::t_in x);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= x;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic go_quiet();
        in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drag is only changed once the block has drained; a draw's last beat comes out
    // before its scan ends, so the task waits on after the queue has emptied.
    task automatic write_drag(input logic [15:0] v);
        go_quiet();
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic ppu_pkg::t_in rand_beat(input logic [1:0] m);
        ppu_pkg::t_in x;
        x.mode         = m;
        x.pos_x        = $urandom;
        x.pos_y        = $urandom;
        x.vel_x        = $urandom;
        x.vel_y        = $urandom;
        x.time_value   = $urandom;
        x.color_start  = $urandom;
        x.color_finish = $urandom;
        x.size_start   = $urandom;
        x.size_finish  = $urandom;
        // Mostly modest values so particles survive a few ticks and move sanely.
        if ($urandom_range(3) != 0) begin
            x.pos_x      = $signed($urandom_range(200000)) - 100000;
            x.pos_y      = $signed($urandom_range(200000)) - 100000;
            x.vel_x      = $signed($urandom_range(400000)) - 200000;
            x.vel_y      = $signed($urandom_range(400000)) - 200000;
            x.size_start = $urandom_range(2000000);
            x.size_finish = $urandom_range(2000000);
            x.time_value = (m == ppu_pkg::M_EMIT) ? $urandom_range(1 << 20)
                                                  : $urandom_range(40000);
        end
        return x;
    endfunction

    function automatic ppu_pkg::t_in make_beat(input logic [1:0] m, input logic [31:0] p,
                                               input logic [31:0] v, input logic [31:0] tv,
                                               input logic [31:0] c0, input logic [31:0] c1,
                                               input logic [31:0] s0, input logic [31:0] s1);
        ppu_pkg::t_in x;
        x = '{m, p, p, v, v, tv, c0, c1, s0, s1};
        return x;
    endfunction

    // A random mix leaning on emits so the pool fills, with draws and ticks
    // interleaved and the odd unused mode thrown in.
    task automatic random_items(input int n);
        int     r;
        logic [1:0] m;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            m = r < 50 ? ppu_pkg::M_EMIT : r < 72 ? ppu_pkg::M_TICK :
                r < 95 ? ppu_pkg::M_DRAW : ppu_pkg::M_NONE;
            send_beat(rand_beat(m));
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes of every field, every mode, zero-life emit,
        // expiry on tick, a draw of an empty pool and the unused mode.
        send_beat(make_beat(ppu_pkg::M_DRAW, 0, 0, 0, 0, 0, 0, 0));
        send_beat(make_beat(ppu_pkg::M_EMIT, 32'h7fffffff, 32'h7fffffff, 32'hffffffff,
                            32'h00000000, 32'hffffffff, 32'h7fffffff, 32'h80000000));
        send_beat(make_beat(ppu_pkg::M_EMIT, 32'h80000000, 32'h80000000, 32'h00010000,
                            32'hffffffff, 32'h00000000, 32'h80000000, 32'h7fffffff));
        send_beat(make_beat(ppu_pkg::M_EMIT, 32'h1000, 32'h30000, 0, 32'h12345678,
                            32'h87654321, 32'h40000, 32'h10000));
        send_beat(make_beat(ppu_pkg::M_EMIT, 0, 32'hfffd0000, 32'h8000, 32'haabbccdd,
                            32'h11223344, 32'hffff0000, 32'h00050000));
        send_beat(make_beat(ppu_pkg::M_EMIT, 5, 7, 32'h10000, 32'hffffffff, 0, 3, 3));
        send_beat(make_beat(ppu_pkg::M_DRAW, 0, 0, 0, 0, 0, 0, 0));
        send_beat(make_beat(ppu_pkg::M_TICK, 0, 0, 32'h4000, 0, 0, 0, 0));
        send_beat(make_beat(ppu_pkg::M_DRAW, 0, 0, 0, 0, 0, 0, 0));
        send_beat(make_beat(ppu_pkg::M_NONE, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                            32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff));
        send_beat(make_beat(ppu_pkg::M_TICK, 0, 0, 32'h0000ffff, 0, 0, 0, 0));
        send_beat(make_beat(ppu_pkg::M_DRAW, 0, 0, 0, 0, 0, 0, 0));
        send_beat(make_beat(ppu_pkg::M_TICK, 0, 0, 32'hffffffff, 0, 0, 0, 0));
        send_beat(make_beat(ppu_pkg::M_DRAW, 0, 0, 0, 0, 0, 0, 0));
        // Wrap the ring head past the last slot.
        for (int i = 0; i < 66; i++) send_beat(rand_beat(ppu_pkg::M_EMIT));
        send_beat(make_beat(ppu_pkg::M_DRAW, 0, 0, 0, 0, 0, 0, 0));

        // Extreme drag values: a large dt with full drag reverses velocity.
        write_drag(16'hffff);
        send_beat(make_beat(ppu_pkg::M_TICK, 0, 0, 32'h100, 0, 0, 0, 0));
        send_beat(make_beat(ppu_pkg::M_TICK, 0, 0, 32'h2000, 0, 0, 0, 0));
        send_beat(make_beat(ppu_pkg::M_DRAW, 0, 0, 0, 0, 0, 0, 0));
        write_drag(16'h0000);
        random_items(20);

        // Busy phases with different idling on each side.
        send_idle = 72;
        write_drag(16'd300);
        random_items(40);
        send_idle = 0;
        recv_stall = 72;
        write_drag(16'd512);
        random_items(40);
        send_idle = 19;
        recv_stall = 19;
        random_items(30);

        // Long receiver hold-off while emits and draws keep coming.
        send_idle = 0;
        recv_stall = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (2000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 20; i++)
                    send_beat(rand_beat(i % 4 == 3 ? ppu_pkg::M_DRAW : ppu_pkg::M_EMIT));
            end
        join
        random_items(16);
        go_quiet();
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Generous guard against a hung handshake.
    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
